>>> hw/rtl/mdb_pkg.sv
// Shared constants, types and codes of the maze depth-first backtracker.
// No dependencies; compile first.
`default_nettype none

package mdb_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int CELL_W     = ROW_W + COL_W;
    localparam int CELL_TOTAL = MAX_ROWS * MAX_COLS;
    localparam int CNT_W      = $clog2(CELL_TOTAL + 1);
    localparam int RDIM_W     = $clog2(MAX_ROWS + 1);
    localparam int CDIM_W     = $clog2(MAX_COLS + 1);

    localparam int EPOCH_W = 4;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

    localparam int CFG_DIM_W  = 7;
    localparam int CFG_POS_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int RAND_W     = 8;
    localparam int COORD_W    = 6;
    localparam int VIS_W      = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL = CFG_IDX_W'(3);

    localparam logic [CFG_DIM_W-1:0] GRID_DIM_RST = CFG_DIM_W'(16);

    typedef enum logic [1:0] {
        ACT_STARTED,
        ACT_CARVED,
        ACT_BACKTRACKED,
        ACT_DONE
    } t_action;

    typedef enum logic [1:0] {
        DIR_N,
        DIR_E,
        DIR_S,
        DIR_W
    } t_dir;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BEGIN,
        ST_START,
        ST_SCAN,
        ST_PICK,
        ST_POP,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic             ok;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_nb;

    typedef struct packed {
        t_action            action;
        logic [COORD_W-1:0] from_row;
        logic [COORD_W-1:0] from_col;
        logic [COORD_W-1:0] to_row;
        logic [COORD_W-1:0] to_col;
        t_dir               direction;
        logic [VIS_W-1:0]   cells_visited;
    } t_rsp;

endpackage

`default_nettype wire

>>> hw/rtl/mdb_ifs.sv
// Request, response and register-write channel interfaces of the maze generator.
// Depends on mdb_pkg.
`default_nettype none

interface mdb_req_if import mdb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              begin_req;
    logic [RAND_W-1:0] random_pick;

    modport source (output valid, begin_req, random_pick, input ready);
    modport sink   (input valid, begin_req, random_pick, output ready);
endinterface

interface mdb_rsp_if import mdb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [COORD_W-1:0] from_row;
    logic [COORD_W-1:0] from_col;
    logic [COORD_W-1:0] to_row;
    logic [COORD_W-1:0] to_col;
    logic [1:0]         direction;
    logic [VIS_W-1:0]   cells_visited;

    modport source (output valid, action, from_row, from_col, to_row, to_col, direction,
                    cells_visited, input ready);
    modport sink   (input valid, action, from_row, from_col, to_row, to_col, direction,
                    cells_visited, output ready);
endinterface

interface mdb_cfg_if import mdb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mdb_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module mdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/maze_dfs_backtracker_step_top.sv
// Maze generator by depth-first walk with an explicit cell stack, one step per request.
// Depends on mdb_pkg, mdb_ifs (req/rsp/cfg channels) and mdb_ram.
//
// Usage: write grid_rows, grid_cols, start_row, start_col over i_cfg (always ready;
// values are latched at the next begin request). Each request on i_req yields exactly
// one response on o_rsp: begin_req = 1 starts a new maze at the start cell, otherwise
// the walk carves one passage, backtracks one cell, or reports done.
// Request flow: a step reads the four neighbour marks, then in ST_PICK carves or
// backtracks; a backtrack that leaves a new top reads it back in ST_POP. A begin runs
// ST_BEGIN and ST_START, and every fifteenth begin sweeps the visited map first.
// The four neighbour lookups share the single read port of the visited memory,
// so they are issued one after another; one request is in flight at a time.
// The visited memory stores an epoch mark per cell, so a begin needs no sweep
// until the mark wraps.
// Reset: synchronous, active low. After reset the visited memory is swept; during the
// sweep i_req is not ready; register writes are still taken.
// A step before any begin reports done with zero coordinates.
// Stall: the response register holds a result until taken; the next request is
// still accepted, and a finished result waits in a second stage.
`default_nettype none

module maze_dfs_backtracker_step_top import mdb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mdb_req_if.sink   i_req,
    mdb_cfg_if.sink   i_cfg,
    mdb_rsp_if.source o_rsp
);

    function automatic logic [RDIM_W-1:0] clamp_rows(input logic [CFG_DIM_W-1:0] v);
        if (v == '0) begin
            return RDIM_W'(1);
        end else if (int'(v) > MAX_ROWS) begin
            return RDIM_W'(MAX_ROWS);
        end
        return RDIM_W'(v);
    endfunction

    function automatic logic [CDIM_W-1:0] clamp_cols(input logic [CFG_DIM_W-1:0] v);
        if (v == '0) begin
            return CDIM_W'(1);
        end else if (int'(v) > MAX_COLS) begin
            return CDIM_W'(MAX_COLS);
        end
        return CDIM_W'(v);
    endfunction

    function automatic logic [ROW_W-1:0] clamp_srow(input logic [CFG_POS_W-1:0] s,
                                                     input logic [RDIM_W-1:0] rows);
        if (int'(s) < int'(rows)) begin
            return ROW_W'(s);
        end
        return ROW_W'(rows - 1'b1);
    endfunction

    function automatic logic [COL_W-1:0] clamp_scol(input logic [CFG_POS_W-1:0] s,
                                                     input logic [CDIM_W-1:0] cols);
        if (int'(s) < int'(cols)) begin
            return COL_W'(s);
        end
        return COL_W'(cols - 1'b1);
    endfunction

    function automatic t_nb nb_cell(input t_dir d, input logic [ROW_W-1:0] r,
                                    input logic [COL_W-1:0] c,
                                    input logic [RDIM_W-1:0] rows,
                                    input logic [CDIM_W-1:0] cols);
        t_nb res;
        res.ok  = 1'b0;
        res.row = r;
        res.col = c;
        unique case (d)
            DIR_N: begin
                res.ok  = (r != '0);
                res.row = r - 1'b1;
            end
            DIR_E: begin
                res.ok  = (int'(c) + 1 < int'(cols));
                res.col = c + 1'b1;
            end
            DIR_S: begin
                res.ok  = (int'(r) + 1 < int'(rows));
                res.row = r + 1'b1;
            end
            DIR_W: begin
                res.ok  = (c != '0);
                res.col = c - 1'b1;
            end
        endcase
        return res;
    endfunction

    function automatic logic [1:0] mod3(input logic [RAND_W-1:0] p);
        logic [3:0] s;
        logic [2:0] t;
        logic [2:0] u;
        s = 4'(p[1:0]) + 4'(p[3:2]) + 4'(p[5:4]) + 4'(p[7:6]);
        t = 3'(s[1:0]) + 3'(s[3:2]);
        u = 3'(t[1:0]) + 3'(t[2]);
        if (u >= 3'd3) begin
            u = u - 3'd3;
        end
        return u[1:0];
    endfunction

    function automatic t_dir sel_dir(input logic [3:0] m, input logic [RAND_W-1:0] p);
        logic [2:0] n;
        logic [1:0] k;
        logic [1:0] seen;
        logic       hit;
        t_dir       d;
        n = 3'($countones(m));
        case (n)
            3'd2:    k = {1'b0, p[0]};
            3'd3:    k = mod3(p);
            3'd4:    k = p[1:0];
            default: k = '0;
        endcase
        seen = '0;
        hit  = 1'b0;
        d    = DIR_N;
        for (int i = 0; i < 4; i++) begin
            if (m[i]) begin
                if (!hit && seen == k) begin
                    d   = t_dir'(2'(i));
                    hit = 1'b1;
                end
                seen = seen + 1'b1;
            end
        end
        return d;
    endfunction

    t_state r_state, n_state;

    logic [CFG_DIM_W-1:0] r_cfg_rows, r_cfg_cols;
    logic [CFG_POS_W-1:0] r_cfg_srow, r_cfg_scol;

    logic [RDIM_W-1:0]  r_act_rows;
    logic [CDIM_W-1:0]  r_act_cols;
    logic [CNT_W-1:0]   r_total;
    logic [ROW_W-1:0]   r_start_row, r_top_row;
    logic [COL_W-1:0]   r_start_col, r_top_col;
    logic [CNT_W-1:0]   r_count, r_visit;
    logic [EPOCH_W-1:0] r_epoch;
    logic [CELL_W-1:0]  r_clr_addr;
    logic               r_clr_begin;
    logic [1:0]         r_nb;
    logic [3:0]         r_free;
    logic               r_rd_ok;
    t_dir               r_rd_dir;
    logic [RAND_W-1:0]  r_pick;
    t_rsp               r_res, r_out;
    logic               r_out_vld;

    logic               vis_we, stk_we;
    logic [CELL_W-1:0]  vis_waddr, vis_raddr, stk_waddr, stk_raddr;
    logic [EPOCH_W-1:0] vis_wdata, vis_rdata;
    logic [CELL_W-1:0]  stk_wdata, stk_rdata;

    logic              req_acc, out_free, is_empty, is_full, scan_go;
    logic              fin, cur_free, can_push;
    t_rsp              fin_res;
    t_state            fin_dest;
    logic [RDIM_W-1:0] cl_rows;
    logic [CDIM_W-1:0] cl_cols;
    logic [ROW_W-1:0]  cl_srow;
    logic [COL_W-1:0]  cl_scol;
    t_nb               nb_issue, nb_new;
    logic [3:0]        free_mask;
    t_dir              pick_dir;
    logic [CNT_W-1:0]  cnt_dec, cnt_dec2;

    assign i_req.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign req_acc     = i_req.valid && i_req.ready;
    assign out_free    = !r_out_vld || o_rsp.ready;
    assign fin_dest    = out_free ? ST_IDLE : ST_HOLD;

    assign is_empty = (r_count == '0);
    assign is_full  = (r_visit >= r_total);
    assign scan_go  = req_acc && !i_req.begin_req && !is_empty && !is_full;
    assign can_push = (int'(r_count) < CELL_TOTAL);

    assign cl_rows = clamp_rows(r_cfg_rows);
    assign cl_cols = clamp_cols(r_cfg_cols);
    assign cl_srow = clamp_srow(r_cfg_srow, cl_rows);
    assign cl_scol = clamp_scol(r_cfg_scol, cl_cols);

    assign nb_issue  = nb_cell(t_dir'(r_nb), r_top_row, r_top_col, r_act_rows, r_act_cols);
    assign cur_free  = r_rd_ok && (vis_rdata != r_epoch);
    assign free_mask = {cur_free, r_free[2:0]};
    assign pick_dir  = sel_dir(free_mask, r_pick);
    assign nb_new    = nb_cell(pick_dir, r_top_row, r_top_col, r_act_rows, r_act_cols);
    assign cnt_dec   = r_count - 1'b1;
    assign cnt_dec2  = r_count - 2'd2;

    mdb_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (1 << CELL_W)
    ) u_vis_ram (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_raddr (vis_raddr),
        .o_rdata (vis_rdata)
    );

    mdb_ram #(
        .WIDTH (CELL_W),
        .DEPTH (1 << CELL_W)
    ) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (&r_clr_addr) begin
                    n_state = r_clr_begin ? ST_START : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (req_acc) begin
                    if (i_req.begin_req) begin
                        n_state = ST_BEGIN;
                    end else if (is_empty || is_full) begin
                        n_state = fin_dest;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_BEGIN: begin
                n_state = (r_epoch == EPOCH_LAST) ? ST_CLEAR : ST_START;
            end
            ST_START: begin
                n_state = fin_dest;
            end
            ST_SCAN: begin
                if (t_dir'(r_nb) == DIR_W) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                if (free_mask == '0 && cnt_dec != '0) begin
                    n_state = ST_POP;
                end else begin
                    n_state = fin_dest;
                end
            end
            ST_POP: begin
                n_state = fin_dest;
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        vis_we    = 1'b0;
        vis_waddr = r_clr_addr;
        vis_wdata = '0;
        vis_raddr = {nb_issue.row, nb_issue.col};
        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = {r_start_row, r_start_col};
        stk_raddr = cnt_dec2[CELL_W-1:0];
        fin       = 1'b0;

        fin_res.action        = ACT_DONE;
        fin_res.from_row      = COORD_W'(r_top_row);
        fin_res.from_col      = COORD_W'(r_top_col);
        fin_res.to_row        = COORD_W'(r_top_row);
        fin_res.to_col        = COORD_W'(r_top_col);
        fin_res.direction     = DIR_N;
        fin_res.cells_visited = VIS_W'(r_visit);

        unique case (r_state)
            ST_CLEAR: begin
                vis_we = 1'b1;
            end
            ST_IDLE: begin
                if (req_acc && !i_req.begin_req && (is_empty || is_full)) begin
                    fin = 1'b1;
                    if (is_empty) begin
                        fin_res.from_row = '0;
                        fin_res.from_col = '0;
                        fin_res.to_row   = '0;
                        fin_res.to_col   = '0;
                    end
                end
            end
            ST_START: begin
                vis_we    = 1'b1;
                vis_waddr = {r_start_row, r_start_col};
                vis_wdata = r_epoch;
                stk_we    = 1'b1;
                fin       = 1'b1;

                fin_res.action        = ACT_STARTED;
                fin_res.from_row      = COORD_W'(r_start_row);
                fin_res.from_col      = COORD_W'(r_start_col);
                fin_res.to_row        = COORD_W'(r_start_row);
                fin_res.to_col        = COORD_W'(r_start_col);
                fin_res.cells_visited = VIS_W'(1);
            end
            ST_PICK: begin
                if (free_mask != '0) begin
                    vis_we    = 1'b1;
                    vis_waddr = {nb_new.row, nb_new.col};
                    vis_wdata = r_epoch;
                    stk_we    = can_push;
                    stk_waddr = r_count[CELL_W-1:0];
                    stk_wdata = {nb_new.row, nb_new.col};
                    fin       = 1'b1;

                    fin_res.action        = ACT_CARVED;
                    fin_res.to_row        = COORD_W'(nb_new.row);
                    fin_res.to_col        = COORD_W'(nb_new.col);
                    fin_res.direction     = pick_dir;
                    fin_res.cells_visited = VIS_W'(r_visit + 1'b1);
                end else if (cnt_dec == '0) begin
                    fin            = 1'b1;
                    fin_res.action = ACT_BACKTRACKED;
                end
            end
            ST_POP: begin
                fin            = 1'b1;
                fin_res.action = ACT_BACKTRACKED;
                fin_res.to_row = COORD_W'(stk_rdata[CELL_W-1:COL_W]);
                fin_res.to_col = COORD_W'(stk_rdata[COL_W-1:0]);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cfg_rows  <= GRID_DIM_RST;
            r_cfg_cols  <= GRID_DIM_RST;
            r_cfg_srow  <= '0;
            r_cfg_scol  <= '0;
            r_count     <= '0;
            r_visit     <= '0;
            r_epoch     <= '0;
            r_clr_addr  <= '0;
            r_clr_begin <= 1'b0;
            r_nb        <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_GRID_ROWS: r_cfg_rows <= i_cfg.data[CFG_DIM_W-1:0];
                    CFG_GRID_COLS: r_cfg_cols <= i_cfg.data[CFG_DIM_W-1:0];
                    CFG_START_ROW: r_cfg_srow <= i_cfg.data[CFG_POS_W-1:0];
                    CFG_START_COL: r_cfg_scol <= i_cfg.data[CFG_POS_W-1:0];
                    default: begin
                    end
                endcase
            end

            if ((fin || r_state == ST_HOLD) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) begin
                        r_epoch     <= EPOCH_FIRST;
                        r_clr_begin <= 1'b0;
                    end
                end
                ST_IDLE: begin
                    r_nb <= scan_go ? 2'd1 : 2'd0;
                end
                ST_BEGIN: begin
                    if (r_epoch == EPOCH_LAST) begin
                        r_clr_begin <= 1'b1;
                    end else begin
                        r_epoch <= r_epoch + 1'b1;
                    end
                end
                ST_START: begin
                    r_count <= CNT_W'(1);
                    r_visit <= CNT_W'(1);
                end
                ST_SCAN: begin
                    r_nb <= r_nb + 1'b1;
                end
                ST_PICK: begin
                    if (free_mask != '0) begin
                        if (can_push) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_visit <= r_visit + 1'b1;
                    end else begin
                        r_count <= cnt_dec;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok  <= nb_issue.ok;
        r_rd_dir <= t_dir'(r_nb);

        if (r_state == ST_SCAN) begin
            r_free[r_rd_dir] <= cur_free;
        end

        if (req_acc) begin
            r_pick <= i_req.random_pick;
            if (i_req.begin_req) begin
                r_act_rows  <= cl_rows;
                r_act_cols  <= cl_cols;
                r_start_row <= cl_srow;
                r_start_col <= cl_scol;
            end
        end

        if (r_state == ST_BEGIN) begin
            r_total <= CNT_W'(r_act_rows) * CNT_W'(r_act_cols);
        end

        if (r_state == ST_START) begin
            r_top_row <= r_start_row;
            r_top_col <= r_start_col;
        end else if (r_state == ST_PICK && free_mask != '0) begin
            r_top_row <= nb_new.row;
            r_top_col <= nb_new.col;
        end else if (r_state == ST_POP) begin
            r_top_row <= stk_rdata[CELL_W-1:COL_W];
            r_top_col <= stk_rdata[COL_W-1:0];
        end

        if (fin) begin
            if (out_free) begin
                r_out <= fin_res;
            end else begin
                r_res <= fin_res;
            end
        end else if (r_state == ST_HOLD && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.action        = r_out.action;
    assign o_rsp.from_row      = r_out.from_row;
    assign o_rsp.from_col      = r_out.from_col;
    assign o_rsp.to_row        = r_out.to_row;
    assign o_rsp.to_col        = r_out.to_col;
    assign o_rsp.direction     = r_out.direction;
    assign o_rsp.cells_visited = r_out.cells_visited;

endmodule

`default_nettype wire

>>> hw/rtl/mdb_chk.sv
// Port-level checker of the maze generator, bound to its top level.
// Depends on mdb_pkg and maze_dfs_backtracker_step_top.
`default_nettype none

module mdb_chk import mdb_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input logic [1:0]         i_action,
    input logic [COORD_W-1:0] i_from_row,
    input logic [COORD_W-1:0] i_from_col,
    input logic [COORD_W-1:0] i_to_row,
    input logic [COORD_W-1:0] i_to_col,
    input logic [1:0]         i_direction,
    input logic [VIS_W-1:0]   i_cells_visited
);

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_action) && $stable(i_to_row)
            && $stable(i_to_col) && $stable(i_cells_visited))
        else $error("response changed while stalled");

    a_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_action == ACT_STARTED |-> i_from_row == i_to_row
            && i_from_col == i_to_col && i_cells_visited == VIS_W'(1))
        else $error("start response malformed");

    a_carve_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_action == ACT_CARVED |->
            (i_direction == DIR_N && i_to_row == i_from_row - 1'b1 && i_to_col == i_from_col)
            || (i_direction == DIR_E && i_to_col == i_from_col + 1'b1 && i_to_row == i_from_row)
            || (i_direction == DIR_S && i_to_row == i_from_row + 1'b1 && i_to_col == i_from_col)
            || (i_direction == DIR_W && i_to_col == i_from_col - 1'b1 && i_to_row == i_from_row))
        else $error("carve does not move one cell in its direction");

    a_done_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_action == ACT_DONE |-> i_from_row == i_to_row
            && i_from_col == i_to_col && i_direction == DIR_N)
        else $error("done response moves");

endmodule

bind maze_dfs_backtracker_step_top mdb_chk u_mdb_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_rsp.valid),
    .i_ready         (o_rsp.ready),
    .i_action        (o_rsp.action),
    .i_from_row      (o_rsp.from_row),
    .i_from_col      (o_rsp.from_col),
    .i_to_row        (o_rsp.to_row),
    .i_to_col        (o_rsp.to_col),
    .i_direction     (o_rsp.direction),
    .i_cells_visited (o_rsp.cells_visited)
);

`default_nettype wire
